>>> sv/frcp_pkg.sv
// ============================================================================
// frcp_pkg
// Shared constants and controller/datapath handshake types for the framed
// register command parser.
// ============================================================================
package frcp_pkg;

  // Default sizing
  localparam int FRCP_NUM_REGS         = 16;
  localparam int FRCP_MAX_PACKET_BYTES = 2048;

  // Frame markers
  localparam logic [7:0] MARK_START_HI = 8'h55;
  localparam logic [7:0] MARK_START_LO = 8'hAA;
  localparam logic [7:0] MARK_END_HI   = 8'h33;
  localparam logic [7:0] MARK_END_LO   = 8'hCC;

  // Command codes
  localparam logic [7:0] CMD_WRITE  = 8'd0;
  localparam logic [7:0] CMD_READ   = 8'd1;
  localparam logic [7:0] CMD_PING   = 8'd2;
  localparam logic [7:0] CMD_TOGGLE = 8'd3;
  localparam logic [7:0] CMD_STOP   = 8'd4;

  // Controller to datapath
  typedef struct packed {
    logic take;     // input word accepted this cycle
    logic apply;    // frame is valid: commit registers / update flags
    logic clr_pkt;  // drop all per-packet state
    logic load;     // load the output register
    logic rej;      // load a rejected item instead of a frame word
  } frcp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_ok;  // markers, length and command check out
    logic out_busy;  // output register holds a word that is stalled
    logic seq_last;  // current sequence index is the final frame word
  } frcp_sts_t;

endpackage

>>> sv/frcp_datapath.sv
// ============================================================================
// frcp_datapath
// Marker search, command/argument capture, pending and committed register
// storage, run/stream flags and the output word register.
// ============================================================================
module frcp_datapath
  import frcp_pkg::*;
#(
  parameter int NUM_REGS         = FRCP_NUM_REGS,
  parameter int MAX_PACKET_BYTES = FRCP_MAX_PACKET_BYTES,
  parameter int CNT_W            = $clog2(2 * NUM_REGS + 6)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       in_data_byte,
  input  frcp_ctl_t        ctl,
  input  logic [CNT_W-1:0] seq,
  output frcp_sts_t        sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_reply_byte,
  output logic             out_reply_last,
  output logic             out_rejected,
  output logic             out_streaming_on,
  output logic             out_running_on,
  output logic             out_clear_timers
);

  localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int WIDE_W = POS_W + 7;
  localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [POS_W-1:0]  POS_MAX      = POS_W'(MAX_PACKET_BYTES);
  localparam logic [WIDE_W-1:0] REL_CMD      = WIDE_W'(2);
  localparam logic [WIDE_W-1:0] REL_ARG      = WIDE_W'(3);
  localparam logic [WIDE_W-1:0] REL_DATA     = WIDE_W'(4);
  localparam logic [WIDE_W-1:0] REL_DATA_END = WIDE_W'(4 + 2 * NUM_REGS);
  localparam logic [WIDE_W-1:0] WRITE_SPAN   = WIDE_W'(2 * NUM_REGS);
  localparam logic [CNT_W-1:0]  SEQ_START_LO = CNT_W'(1);
  localparam logic [CNT_W-1:0]  SEQ_CMD      = CNT_W'(2);
  localparam logic [CNT_W-1:0]  SEQ_ARG      = CNT_W'(3);
  localparam logic [CNT_W-1:0]  SEQ_DATA     = CNT_W'(4);
  localparam logic [CNT_W-1:0]  SEQ_DATA_END = CNT_W'(4 + 2 * NUM_REGS);

  // Per-packet state
  logic [POS_W-1:0] pos_r;
  logic [7:0]       prev_r;
  logic             start_seen_r;
  logic [POS_W-1:0] start_off_r;
  logic             end_seen_r;
  logic [POS_W-1:0] end_off_r;
  logic [7:0]       cmd_r;
  logic [7:0]       arg_r;

  // Register storage
  logic [15:0] pend_r [NUM_REGS];
  logic [15:0] regs_r [NUM_REGS];
  logic        stream_r;
  logic        run_r;
  logic        clr_r;

  // Output word register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_rej_r;
  logic       out_stream_r;
  logic       out_run_r;
  logic       out_clr_r;

  logic              take_ok;
  logic              hit_start;
  logic              hit_end;
  logic [WIDE_W-1:0] pos_w;
  logic [WIDE_W-1:0] soff_w;
  logic [WIDE_W-1:0] eoff_w;
  logic [WIDE_W-1:0] rel;
  logic [WIDE_W-1:0] wr_off;
  logic [IDX_W-1:0]  wr_k;
  logic              past_start;
  logic              in_data_zone;
  logic              cmd_short;
  logic              is_read;
  logic              data_zone;
  logic [CNT_W-1:0]  seq_tail;
  logic [CNT_W-1:0]  rd_off;
  logic [IDX_W-1:0]  rd_k;
  logic [15:0]       rd_word;
  logic [7:0]        frame_byte;

  // --------------------------------------------------------------------------
  // Byte capture
  // --------------------------------------------------------------------------
  assign take_ok   = ctl.take && (pos_r < POS_MAX);
  assign hit_start = take_ok && (pos_r != '0) && !start_seen_r &&
                     (prev_r == MARK_START_HI) && (in_data_byte == MARK_START_LO);
  assign hit_end   = take_ok && (pos_r != '0) && !end_seen_r &&
                     (prev_r == MARK_END_HI) && (in_data_byte == MARK_END_LO);

  assign pos_w        = WIDE_W'(pos_r);
  assign soff_w       = WIDE_W'(start_off_r);
  assign eoff_w       = WIDE_W'(end_off_r);
  assign rel          = pos_w - soff_w;
  assign wr_off       = rel - REL_DATA;
  assign wr_k         = wr_off[IDX_W:1];
  assign past_start   = start_seen_r && (pos_w > soff_w + WIDE_W'(1));
  assign in_data_zone = (rel >= REL_DATA) && (rel < REL_DATA_END);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_pkt) begin
      pos_r        <= '0;
      prev_r       <= '0;
      start_seen_r <= 1'b0;
      start_off_r  <= '0;
      end_seen_r   <= 1'b0;
      end_off_r    <= '0;
      cmd_r        <= '0;
      arg_r        <= '0;
    end else if (take_ok) begin
      if (hit_start) begin
        start_seen_r <= 1'b1;
        start_off_r  <= pos_r - POS_W'(1);
      end
      if (hit_end) begin
        end_seen_r <= 1'b1;
        end_off_r  <= pos_r - POS_W'(1);
      end
      if (past_start && rel == REL_CMD) begin
        cmd_r <= in_data_byte;
      end
      if (past_start && rel == REL_ARG) begin
        arg_r <= in_data_byte;
      end
      prev_r <= in_data_byte;
      pos_r  <= pos_r + POS_W'(1);
    end
  end

  // Pending words: big-endian, high byte first
  always_ff @(posedge clk) begin
    if (take_ok && past_start && in_data_zone) begin
      if (wr_off[0]) begin
        pend_r[wr_k][7:0] <= in_data_byte;
      end else begin
        pend_r[wr_k][15:8] <= in_data_byte;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame check and commit
  // --------------------------------------------------------------------------
  assign cmd_short = (cmd_r == CMD_READ) || (cmd_r == CMD_PING) ||
                     (cmd_r == CMD_TOGGLE) || (cmd_r == CMD_STOP);

  assign sts.frame_ok = start_seen_r && end_seen_r &&
    (((cmd_r == CMD_WRITE) && (eoff_w == soff_w + REL_DATA + WRITE_SPAN)) ||
     (cmd_short && (eoff_w == soff_w + REL_DATA)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (ctl.apply && cmd_r == CMD_WRITE) begin
      regs_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_r <= 1'b0;
      run_r    <= 1'b1;
      clr_r    <= 1'b0;
    end else if (ctl.clr_pkt) begin
      clr_r <= 1'b0;
    end else if (ctl.apply) begin
      case (cmd_r)
        CMD_TOGGLE: begin
          stream_r <= !stream_r;
          clr_r    <= !stream_r;
        end
        CMD_STOP: run_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Response word select
  // --------------------------------------------------------------------------
  assign is_read      = (cmd_r == CMD_READ);
  assign data_zone    = is_read && (seq >= SEQ_DATA) && (seq < SEQ_DATA_END);
  assign seq_tail     = is_read ? SEQ_DATA_END : SEQ_DATA;
  assign sts.seq_last = (seq == seq_tail + CNT_W'(1));
  assign rd_off       = seq - SEQ_DATA;
  assign rd_k         = rd_off[IDX_W:1];
  assign rd_word      = regs_r[rd_k];

  always_comb begin
    if (data_zone) begin
      frame_byte = rd_off[0] ? rd_word[7:0] : rd_word[15:8];
    end else if (seq == '0) begin
      frame_byte = MARK_START_HI;
    end else if (seq == SEQ_START_LO) begin
      frame_byte = MARK_START_LO;
    end else if (seq == SEQ_CMD) begin
      frame_byte = cmd_r;
    end else if (seq == SEQ_ARG) begin
      frame_byte = arg_r;
    end else if (seq == seq_tail) begin
      frame_byte = MARK_END_HI;
    end else begin
      frame_byte = MARK_END_LO;
    end
  end

  // --------------------------------------------------------------------------
  // Output word register
  // --------------------------------------------------------------------------
  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_byte_r   <= ctl.rej ? 8'h00 : frame_byte;
      out_last_r   <= ctl.rej || sts.seq_last;
      out_rej_r    <= ctl.rej;
      out_stream_r <= stream_r;
      out_run_r    <= run_r;
      out_clr_r    <= !ctl.rej && clr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_byte   = out_byte_r;
  assign out_reply_last   = out_last_r;
  assign out_rejected     = out_rej_r;
  assign out_streaming_on = out_stream_r;
  assign out_running_on   = out_run_r;
  assign out_clear_timers = out_clr_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clr_pkt_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr_pkt |=> (pos_r == '0) && !start_seen_r && !end_seen_r)
    else $error("per-packet state not cleared");

  a_rej_item_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (out_last_r && out_byte_r == 8'h00 && !out_clr_r))
    else $error("rejected item malformed");

  a_apply_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.apply |-> sts.frame_ok)
    else $error("commit on invalid frame");

endmodule

>>> sv/frcp_ctrl.sv
// ============================================================================
// frcp_ctrl
// Sequencer: take input words, check the frame on the last word, then step
// the response words out through the datapath output register.
// ============================================================================
module frcp_ctrl
  import frcp_pkg::*;
#(
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_packet_end,
  output logic             in_stall,
  input  frcp_sts_t        sts,
  output frcp_ctl_t        ctl,
  output logic [CNT_W-1:0] seq
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;
  localparam logic [1:0] S_REJECT = 2'd3;

  logic [1:0]       st_r;
  logic [1:0]       st_nxt;
  logic [CNT_W-1:0] seq_r;
  logic [CNT_W-1:0] seq_nxt;

  always_comb begin
    ctl     = '0;
    st_nxt  = st_r;
    seq_nxt = seq_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          if (in_packet_end) begin
            st_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        seq_nxt = '0;
        if (sts.frame_ok) begin
          ctl.apply = 1'b1;
          st_nxt    = S_EMIT;
        end else begin
          st_nxt = S_REJECT;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          ctl.load = 1'b1;
          seq_nxt  = seq_r + CNT_W'(1);
          if (sts.seq_last) begin
            ctl.clr_pkt = 1'b1;
            st_nxt      = S_IDLE;
          end
        end
      end
      S_REJECT: begin
        if (!sts.out_busy) begin
          ctl.load    = 1'b1;
          ctl.rej     = 1'b1;
          ctl.clr_pkt = 1'b1;
          st_nxt      = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      seq_r <= '0;
    end else begin
      st_r  <= st_nxt;
      seq_r <= seq_nxt;
    end
  end

  assign in_stall = (st_r != S_IDLE);
  assign seq      = seq_r;

  a_end_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && in_valid && in_packet_end) |=> (st_r == S_CHECK))
    else $error("last word did not start the frame check");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !sts.out_busy)
    else $error("output register overwritten while stalled");

  a_check_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CHECK) |=> ((st_r == S_EMIT || st_r == S_REJECT) && seq_r == '0))
    else $error("bad exit from frame check");

endmodule

>>> sv/framed_register_command_parser_unit.sv
// ============================================================================
// framed_register_command_parser_unit
// Byte-wide framed command parser: finds the 55 AA / 33 CC markers, takes
// command and argument, writes or reads a bank of 16-bit registers and
// answers each packet with a response frame or one rejected word.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_data_byte, in_packet_end
//  out     | output    | out_valid/out_stall| out_reply_byte, out_reply_last,
//          |           |                    | out_rejected, out_streaming_on,
//          |           |                    | out_running_on, out_clear_timers
//
//  Input words are taken while idle; the last word is followed by the frame
//  check and the response words (6, 6 + 2*NUM_REGS for a read, 1 rejected).
//  Input stalls from the check until the final response word is loaded;
//  out_stall stretches that phase word for word.
//  Reset (synchronous, rst_n low) clears packet state, the register bank
//  and streaming, and sets running; no clearing pass follows.
//
module framed_register_command_parser_unit
  import frcp_pkg::*;
#(
  parameter int NUM_REGS         = FRCP_NUM_REGS,
  parameter int MAX_PACKET_BYTES = FRCP_MAX_PACKET_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_packet_end,
  // Response words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_reply_byte,
  output logic       out_reply_last,
  output logic       out_rejected,
  output logic       out_streaming_on,
  output logic       out_running_on,
  output logic       out_clear_timers
);

  // Sequence counter spans every word of the longest response frame
  localparam int CNT_W = $clog2(2 * NUM_REGS + 6);

  frcp_ctl_t        ctl;
  frcp_sts_t        sts;
  logic [CNT_W-1:0] seq;

  // Controller: hold input during check/emit/reject, advance the word sequence
  frcp_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_packet_end (in_packet_end),
    .in_stall      (in_stall),
    .sts           (sts),
    .ctl           (ctl),
    .seq           (seq)
  );

  // Datapath: marker search, capture, register bank, output register
  frcp_datapath #(
    .NUM_REGS         (NUM_REGS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .CNT_W            (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .ctl              (ctl),
    .seq              (seq),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_reply_byte   (out_reply_byte),
    .out_reply_last   (out_reply_last),
    .out_rejected     (out_rejected),
    .out_streaming_on (out_streaming_on),
    .out_running_on   (out_running_on),
    .out_clear_timers (out_clear_timers)
  );

endmodule

>>> test/framed_register_command_parser_unit_tb.sv
// ============================================================================
// framed_register_command_parser_unit_tb
// Self-checking bench for the framed command parser. A directed table of
// packets comes first, then random packets, mostly well formed. A stream
// predictor follows every accepted input word and queues the response words
// it expects. Both handshakes idle at random.
// ============================================================================
module framed_register_command_parser_unit_tb;
  import frcp_pkg::*;

  localparam int DATA_WORDS     = 2 * FRCP_NUM_REGS;  // write payload length
  localparam int RANDOM_WORDS   = 100;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving

  // One response word as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rej;
    logic       stream;
    logic       run;
    logic       clr;
  } reply_t;

  // One packet of the directed table. Layout: lead words, then
  // [33 CC if end_first] [55 AA] cmd arg body [33 CC] tail.
  // The typed rows carry the reject word written out by hand.
  typedef struct packed {
    int unsigned lead;
    bit          has_start;
    bit          has_end;
    bit          end_first;
    bit          bare;       // no command and argument words
    logic [7:0]  cmd;
    logic [7:0]  arg;
    int unsigned body;
    logic [7:0]  fill;
    int unsigned tail;
    bit          typed;
    logic        t_stream;
    logic        t_run;
  } frame_row_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_packet_end = 1'b0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [7:0] out_reply_byte;
  logic       out_reply_last;
  logic       out_rejected;
  logic       out_streaming_on;
  logic       out_running_on;
  logic       out_clear_timers;

  // Travel with each input word: the typed reject of a directed row
  logic word_typed   = 1'b0;
  logic typed_stream = 1'b0;
  logic typed_run    = 1'b0;

  bit          hold_pending = 1'b0;
  int          mismatches   = 0;
  int          idle_cycles  = 0;
  logic [7:0]  pkt[$];
  reply_t      frame_replies[$];
  reply_t      pending_replies[$];
  reply_t      want;

  // Predictor state, reset values
  int unsigned byte_pos   = 0;
  logic [7:0]  prev_octet = 8'h00;
  logic        sof_found  = 1'b0;
  int unsigned sof_at     = 0;
  logic        eof_found  = 1'b0;
  int unsigned eof_at     = 0;
  logic [7:0]  cmd_q      = 8'h00;
  logic [7:0]  arg_q      = 8'h00;
  logic [15:0] staged_regs [FRCP_NUM_REGS] = '{default: 16'h0000};
  logic [15:0] reg_bank    [FRCP_NUM_REGS] = '{default: 16'h0000};
  logic        stream_q   = 1'b0;
  logic        run_q      = 1'b1;

  // lead strt end 1st bare cmd        arg   body fill  tail typd strm run
  frame_row_t directed_rows [18] = '{
    '{1, '0, '0, '0, '1, CMD_WRITE,  8'h00, 0, 8'h00, 0, '1, '0, '1},  // one-word packet
    '{0, '0, '0, '0, '0, 8'hFF,      8'hFF, 2, 8'hFF, 0, '1, '0, '1},  // all ones, no marker
    '{0, '1, '1, '0, '0, CMD_PING,   8'h00, 0, 8'h00, 0, '0, '0, '1},
    '{0, '1, '1, '0, '0, CMD_READ,   8'hFF, 0, 8'h00, 0, '0, '0, '1},  // bank after reset
    '{0, '1, '1, '0, '0, 8'h05,      8'h00, 0, 8'h00, 0, '1, '0, '1},  // first unknown code
    '{0, '1, '1, '0, '0, 8'hFF,      8'h80, 0, 8'h00, 0, '1, '0, '1},  // top unknown code
    '{0, '1, '1, '1, '0, CMD_PING,   8'h01, 0, 8'h00, 0, '1, '0, '1},  // end marker first
    '{2, '1, '0, '0, '0, CMD_PING,   8'h02, 0, 8'h00, 0, '1, '0, '1},  // end marker missing
    '{0, '0, '1, '0, '0, CMD_PING,   8'h03, 0, 8'h00, 0, '1, '0, '1},  // start marker missing
    '{0, '1, '1, '0, '0, CMD_PING,   8'h04, 1, 8'h5A, 0, '1, '0, '1},  // one word too long
    '{0, '1, '1, '0, '0, CMD_WRITE,  8'h05, 31, 8'hAB, 0, '1, '0, '1}, // write one word short
    '{3, '1, '1, '0, '0, CMD_WRITE,  8'h06, 32, 8'hFF, 1, '0, '0, '1}, // all ones into bank
    '{0, '1, '1, '0, '0, CMD_READ,   8'h07, 0, 8'h00, 0, '0, '0, '1},
    '{0, '1, '1, '0, '0, CMD_TOGGLE, 8'h08, 0, 8'h00, 0, '0, '0, '1},  // streaming on
    '{0, '1, '1, '0, '0, 8'h80,      8'h09, 0, 8'h00, 0, '1, '1, '1},  // reject while on
    '{0, '1, '1, '0, '0, CMD_TOGGLE, 8'h0A, 0, 8'h00, 0, '0, '0, '1},  // streaming off
    '{0, '1, '1, '0, '0, CMD_STOP,   8'h0B, 0, 8'h00, 0, '0, '0, '1},
    '{0, '1, '1, '0, '0, 8'h06,      8'h0C, 0, 8'h00, 0, '1, '0, '0}   // reject after stop
  };

  framed_register_command_parser_unit dut (.*);

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(8, 40);
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic push_reply(input logic [7:0] data, input logic last, input logic rej,
                            input logic clr);
    frame_replies.push_back('{data: data, last: last, rej: rej, stream: stream_q,
                              run: run_q, clr: clr});
  endtask

  // Advance the parser by one accepted word; leave its response words in
  // frame_replies.
  task automatic predict_word(input logic [7:0] b, input logic eop);
    int unsigned rel;
    logic        frame_ok;
    logic        clr;
    frame_replies.delete();
    // Drop words once the position counter has saturated
    if (byte_pos < FRCP_MAX_PACKET_BYTES) begin
      if (byte_pos >= 1) begin
        if (!sof_found && prev_octet == MARK_START_HI && b == MARK_START_LO) begin
          sof_found = 1'b1;
          sof_at    = byte_pos - 1;
        end
        if (!eof_found && prev_octet == MARK_END_HI && b == MARK_END_LO) begin
          eof_found = 1'b1;
          eof_at    = byte_pos - 1;
        end
      end
      if (sof_found && byte_pos > sof_at + 1) begin
        rel = byte_pos - sof_at;
        if (rel == 2)
          cmd_q = b;
        else if (rel == 3)
          arg_q = b;
        else if (rel >= 4 && rel < 4 + DATA_WORDS) begin
          // Big-endian pairs: high byte first
          if (((rel - 4) & 1) == 0)
            staged_regs[(rel - 4) >> 1][15:8] = b;
          else
            staged_regs[(rel - 4) >> 1][7:0] = b;
        end
      end
      prev_octet = b;
      byte_pos++;
    end
    if (!eop)
      return;

    frame_ok = 1'b0;
    clr      = 1'b0;
    if (sof_found && eof_found) begin
      if (cmd_q == CMD_WRITE)
        frame_ok = (eof_at == sof_at + 4 + DATA_WORDS);
      else if (cmd_q <= CMD_STOP)
        frame_ok = (eof_at == sof_at + 4);
    end

    if (!frame_ok)
      push_reply(8'h00, 1'b1, 1'b1, 1'b0);
    else begin
      case (cmd_q)
        CMD_WRITE: reg_bank = staged_regs;
        CMD_TOGGLE: begin
          clr      = !stream_q;
          stream_q = !stream_q;
        end
        CMD_STOP: run_q = 1'b0;
        default: ;
      endcase
      push_reply(MARK_START_HI, 1'b0, 1'b0, clr);
      push_reply(MARK_START_LO, 1'b0, 1'b0, clr);
      push_reply(cmd_q, 1'b0, 1'b0, clr);
      push_reply(arg_q, 1'b0, 1'b0, clr);
      if (cmd_q == CMD_READ) begin
        foreach (reg_bank[i]) begin
          push_reply(reg_bank[i][15:8], 1'b0, 1'b0, clr);
          push_reply(reg_bank[i][7:0], 1'b0, 1'b0, clr);
        end
      end
      push_reply(MARK_END_HI, 1'b0, 1'b0, clr);
      push_reply(MARK_END_LO, 1'b1, 1'b0, clr);
    end

    // Drop all per-packet state
    byte_pos   = 0;
    prev_octet = 8'h00;
    sof_found  = 1'b0;
    sof_at     = 0;
    eof_found  = 1'b0;
    eof_at     = 0;
    cmd_q      = 8'h00;
    arg_q      = 8'h00;
  endtask

  // Lay out one packet in pkt; rand_fill replaces lead, body and tail
  // words by random ones.
  task automatic build_frame(input frame_row_t r, input bit rand_fill);
    pkt.delete();
    repeat (r.lead) pkt.push_back(rand_fill ? 8'($urandom_range(0, 255)) : 8'h00);
    if (r.end_first) begin
      pkt.push_back(MARK_END_HI);
      pkt.push_back(MARK_END_LO);
    end
    if (r.has_start) begin
      pkt.push_back(MARK_START_HI);
      pkt.push_back(MARK_START_LO);
    end
    if (!r.bare) begin
      pkt.push_back(r.cmd);
      pkt.push_back(r.arg);
    end
    repeat (r.body) pkt.push_back(rand_fill ? 8'($urandom_range(0, 255)) : r.fill);
    if (r.has_end && !r.end_first) begin
      pkt.push_back(MARK_END_HI);
      pkt.push_back(MARK_END_LO);
    end
    repeat (r.tail) pkt.push_back(rand_fill ? 8'($urandom_range(0, 255)) : 8'h00);
  endtask

  // Offer the words of pkt one by one; hold each until it is taken.
  task automatic send_packet(input bit typed, input logic t_stream, input logic t_run,
                             input bit calm);
    int unsigned gap;
    for (int i = 0; i < pkt.size(); i++) begin
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= pkt[i];
      in_packet_end <= (i == pkt.size() - 1);
      word_typed    <= typed;
      typed_stream  <= t_stream;
      typed_run     <= t_run;
      do @(posedge clk); while (in_stall !== 1'b0);
    end
  endtask

  // Input side: every word taken advances the predictor. A typed row
  // supplies its own reject word instead of the predicted one.
  always @(posedge clk) begin
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      predict_word(in_data_byte, in_packet_end);
      if (in_packet_end && word_typed)
        pending_replies.push_back('{data: 8'h00, last: 1'b1, rej: 1'b1,
                                    stream: typed_stream, run: typed_run, clr: 1'b0});
      else
        foreach (frame_replies[i]) pending_replies.push_back(frame_replies[i]);
    end
  end

  // Output side: compare each word taken with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0)
        report_mismatch("reply word with nothing pending", out_reply_byte, 8'h00);
      else begin
        want = pending_replies.pop_front();
        if (out_reply_byte !== want.data)
          report_mismatch("reply_byte", out_reply_byte, want.data);
        if (out_reply_last !== want.last)
          report_mismatch("reply_last", 8'(out_reply_last), 8'(want.last));
        if (out_rejected !== want.rej)
          report_mismatch("rejected", 8'(out_rejected), 8'(want.rej));
        if (out_streaming_on !== want.stream)
          report_mismatch("streaming_on", 8'(out_streaming_on), 8'(want.stream));
        if (out_running_on !== want.run)
          report_mismatch("running_on", 8'(out_running_on), 8'(want.run));
        if (out_clear_timers !== want.clr)
          report_mismatch("clear_timers", 8'(out_clear_timers), 8'(want.clr));
      end
    end
  end

  // Receiver: random stalls, free stretches, and one long hold-off on request
  initial begin : receiver
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? 60 : $urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t  row;
    int unsigned random_words;
    int unsigned pkt_count;
    int unsigned kind;
    int unsigned pick;
    random_words = 0;
    pkt_count    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      build_frame(directed_rows[i], 1'b0);
      send_packet(directed_rows[i].typed, directed_rows[i].t_stream,
                  directed_rows[i].t_run, $urandom_range(0, 2) == 0);
    end

    // Random packets: mostly well formed, the rest noise or broken frames
    while (random_words < RANDOM_WORDS) begin
      // Hold the receiver off while words keep coming, so the block backs up
      if (pkt_count == 3)
        hold_pending = 1'b1;

      row           = '0;
      row.lead      = $urandom_range(0, 3);
      row.has_start = 1'b1;
      row.has_end   = 1'b1;
      row.tail      = $urandom_range(0, 2);
      row.arg       = 8'($urandom_range(0, 255));
      pick          = $urandom_range(0, 9);
      row.cmd       = (pick < 2) ? CMD_WRITE : (pick < 4) ? CMD_READ :
                      (pick < 6) ? CMD_PING : (pick < 9) ? CMD_TOGGLE : CMD_STOP;
      row.body      = (row.cmd == CMD_WRITE) ? DATA_WORDS : 0;

      kind = $urandom_range(0, 99);
      if (kind >= 60 && kind < 75) begin
        // Noise: random words with no markers laid in
        row.bare      = 1'b1;
        row.has_start = 1'b0;
        row.has_end   = 1'b0;
        row.lead      = $urandom_range(1, 12);
        row.tail      = 0;
      end else if (kind >= 75 && kind < 85)
        row.body = $urandom_range(0, DATA_WORDS + 2);
      else if (kind >= 85 && kind < 93)
        row.cmd = 8'($urandom_range(5, 255));
      else if (kind >= 93) begin
        case ($urandom_range(0, 2))
          0: row.has_start = 1'b0;
          1: row.has_end   = 1'b0;
          default: row.end_first = 1'b1;
        endcase
      end

      build_frame(row, 1'b1);
      random_words += pkt.size();
      send_packet(1'b0, 1'b0, 1'b0, $urandom_range(0, 3) == 0);
      pkt_count++;
    end

    in_valid <= 1'b0;
    // Let the input monitor queue the last packet's words first
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
